FILE: rtl/core/fbmvn_pkg.sv
// shared constants and types for the fractal value noise pipeline
package fbmvn_pkg;

	localparam int DEF_MAX_OCTAVES = 8;
	localparam int DEF_FRAC_BITS = 16;

	localparam int COORD_W = 32;
	localparam int OUT_W = 18;
	localparam int OCT_W = 4;
	localparam int SEED_W = 32;
	localparam int HASH_W = 32;
	localparam int K_W = OCT_W + 1;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 32;

	localparam int WEIGHT_BITS = 16;
	localparam int UNIT_BITS = 24;
	localparam int DEN_SHIFT = UNIT_BITS - WEIGHT_BITS;
	localparam int QUOT_BITS = 17;

	localparam logic [HASH_W-1:0] HASH_CX = 32'h8da6b343;
	localparam logic [HASH_W-1:0] HASH_CY = 32'hd8163841;
	localparam logic [HASH_W-1:0] HASH_SEED = 32'hcb1ab31f;
	localparam logic [HASH_W-1:0] HASH_M1 = 32'h7feb352d;
	localparam logic [HASH_W-1:0] HASH_M2 = 32'h846ca68b;
	localparam logic [HASH_W-1:0] SEED_STEP = 32'd101;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_OCTAVE_COUNT = 1'b0,
		REG_NOISE_SEED = 1'b1
	} cfg_reg_t;

endpackage

FILE: rtl/core/fbm_value_noise.sv
// fractal value noise pipeline, one 2d point in and one noise value out per request
// Takes one point per clock unless a stalled output has backed up to the input, and
// returns one result per point, in order. Every octave has its own lane of hash and
// blend hardware, so the octave count changes only which lanes are summed, not the
// rate; the normalizing division is a pipelined restoring divider, one quotient bit
// per stage, which sets most of the latency. Stalls on the output back up stage by
// stage, and empty stages keep filling while the output waits. octave_count of zero
// counts as one octave and values above MAX_OCTAVES saturate. Write configuration
// only while the pipeline is empty.
module fbm_value_noise #(
	parameter int MAX_OCTAVES = fbmvn_pkg::DEF_MAX_OCTAVES,
	parameter int FRAC_BITS = fbmvn_pkg::DEF_FRAC_BITS
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [fbmvn_pkg::CFG_IDX_W-1:0]      cfg_idx,
	input  logic [fbmvn_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic signed [fbmvn_pkg::COORD_W-1:0] coord_x,
	input  logic signed [fbmvn_pkg::COORD_W-1:0] coord_y,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [fbmvn_pkg::OUT_W-1:0]   noise_value
);
	import fbmvn_pkg::*;

	localparam int SW = UNIT_BITS + MAX_OCTAVES + 2;
	localparam int NW = SW - 1;
	localparam int DW = MAX_OCTAVES + DEN_SHIFT;
	localparam int DIV_ST0 = 12;
	localparam int NST = DIV_ST0 + QUOT_BITS;
	localparam int PW = 2 * UNIT_BITS - 7;

	// configuration
	logic [OCT_W-1:0] octave_count_q;
	logic [SEED_W-1:0] noise_seed_q;
	logic [K_W-1:0] k_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			octave_count_q <= OCT_W'(1);
			noise_seed_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_idx))
				REG_OCTAVE_COUNT: octave_count_q <= cfg_data[OCT_W-1:0];
				REG_NOISE_SEED:   noise_seed_q <= cfg_data[SEED_W-1:0];
				default:          ;
			endcase
		end
	end

	always_comb begin
		if (octave_count_q == '0) begin
			k_eff = K_W'(1);
		end else if ({1'b0, octave_count_q} > K_W'(MAX_OCTAVES)) begin
			k_eff = K_W'(MAX_OCTAVES);
		end else begin
			k_eff = {1'b0, octave_count_q};
		end
	end

	// stage valids and load enables, a stage loads when empty or when the next one loads
	logic [NST:1] vld_q;
	logic [NST:1] vin;
	logic [NST:1] en;

	assign vin = {vld_q[NST-1:1], in_valid};
	assign en[NST] = !vld_q[NST] || !out_stall;
	for (genvar i = 1; i < NST; i++) begin : g_en
		assign en[i] = !vld_q[i] || en[i+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int i = 1; i <= NST; i++) begin
				if (en[i]) begin
					vld_q[i] <= vin[i];
				end
			end
		end
	end

	assign in_stall = !en[1];
	assign out_valid = vld_q[NST];

	// per octave lane registers
	logic [HASH_W-1:0] cx_s1 [MAX_OCTAVES];
	logic [HASH_W-1:0] cx1_s1 [MAX_OCTAVES];
	logic [HASH_W-1:0] cy_s1 [MAX_OCTAVES];
	logic [HASH_W-1:0] cy1_s1 [MAX_OCTAVES];
	logic [HASH_W-1:0] sd_s1 [MAX_OCTAVES];
	logic [WEIGHT_BITS-1:0] tx_s1 [MAX_OCTAVES];
	logic [WEIGHT_BITS-1:0] ty_s1 [MAX_OCTAVES];

	logic [HASH_W-1:0] pcx0_s2 [MAX_OCTAVES];
	logic [HASH_W-1:0] pcx1_s2 [MAX_OCTAVES];
	logic [HASH_W-1:0] pcy0_s2 [MAX_OCTAVES];
	logic [HASH_W-1:0] pcy1_s2 [MAX_OCTAVES];
	logic [HASH_W-1:0] psd_s2 [MAX_OCTAVES];
	logic [WEIGHT_BITS-1:0] tx_s2 [MAX_OCTAVES];
	logic [WEIGHT_BITS-1:0] ty_s2 [MAX_OCTAVES];
	logic [WEIGHT_BITS-1:0] ttx_s2 [MAX_OCTAVES];
	logic [WEIGHT_BITS-1:0] tty_s2 [MAX_OCTAVES];

	logic [HASH_W-1:0] ha_s3 [MAX_OCTAVES][4];
	logic [WEIGHT_BITS-1:0] wx_s3 [MAX_OCTAVES];
	logic [WEIGHT_BITS-1:0] wy_s3 [MAX_OCTAVES];

	logic [HASH_W-1:0] hb_s4 [MAX_OCTAVES][4];
	logic [WEIGHT_BITS-1:0] wx_s4 [MAX_OCTAVES];
	logic [WEIGHT_BITS-1:0] wy_s4 [MAX_OCTAVES];

	logic [HASH_W-1:0] hc_s5 [MAX_OCTAVES][4];
	logic [WEIGHT_BITS-1:0] wx_s5 [MAX_OCTAVES];
	logic [WEIGHT_BITS-1:0] wy_s5 [MAX_OCTAVES];

	logic [UNIT_BITS-1:0] cv_s6 [MAX_OCTAVES][4];
	logic [WEIGHT_BITS-1:0] wx_s6 [MAX_OCTAVES];
	logic [WEIGHT_BITS-1:0] wy_s6 [MAX_OCTAVES];

	logic [UNIT_BITS-1:0] top_s7 [MAX_OCTAVES];
	logic [UNIT_BITS-1:0] bot_s7 [MAX_OCTAVES];
	logic [WEIGHT_BITS-1:0] wy_s7 [MAX_OCTAVES];

	logic signed [UNIT_BITS:0] n_s8 [MAX_OCTAVES];
	logic signed [SW-1:0] term_s9 [MAX_OCTAVES];

	for (genvar o = 0; o < MAX_OCTAVES; o++) begin : g_lane
		logic signed [63:0] scx;
		logic signed [63:0] scy;
		logic [WEIGHT_BITS-1:0] tx;
		logic [WEIGHT_BITS-1:0] ty;
		logic [2*WEIGHT_BITS-1:0] sqx;
		logic [2*WEIGHT_BITS-1:0] sqy;
		logic [2*WEIGHT_BITS+1:0] fpx;
		logic [2*WEIGHT_BITS+1:0] fpy;
		logic [HASH_W-1:0] hm [4];
		logic [PW-1:0] tpp;
		logic [PW-1:0] btp;
		logic [PW-1:0] vvp;
		logic [UNIT_BITS-1:0] vv;
		logic [K_W-1:0] sh;

		assign scx = 64'(coord_x) <<< o;
		assign scy = 64'(coord_y) <<< o;

		if (FRAC_BITS >= WEIGHT_BITS) begin : g_trunc
			assign tx = scx[FRAC_BITS-1 -: WEIGHT_BITS];
			assign ty = scy[FRAC_BITS-1 -: WEIGHT_BITS];
		end else begin : g_widen
			assign tx = {scx[FRAC_BITS-1:0], {(WEIGHT_BITS-FRAC_BITS){1'b0}}};
			assign ty = {scy[FRAC_BITS-1:0], {(WEIGHT_BITS-FRAC_BITS){1'b0}}};
		end

		always_ff @(posedge clk) begin
			if (en[1]) begin
				cx_s1[o] <= scx[FRAC_BITS +: HASH_W];
				cx1_s1[o] <= scx[FRAC_BITS +: HASH_W] + HASH_W'(1);
				cy_s1[o] <= scy[FRAC_BITS +: HASH_W];
				cy1_s1[o] <= scy[FRAC_BITS +: HASH_W] + HASH_W'(1);
				sd_s1[o] <= noise_seed_q + SEED_STEP * HASH_W'(o);
				tx_s1[o] <= tx;
				ty_s1[o] <= ty;
			end
		end

		// lattice products and the square of the fraction
		assign sqx = (2*WEIGHT_BITS)'(tx_s1[o]) * (2*WEIGHT_BITS)'(tx_s1[o]);
		assign sqy = (2*WEIGHT_BITS)'(ty_s1[o]) * (2*WEIGHT_BITS)'(ty_s1[o]);

		always_ff @(posedge clk) begin
			if (en[2]) begin
				pcx0_s2[o] <= cx_s1[o] * HASH_CX;
				pcx1_s2[o] <= cx1_s1[o] * HASH_CX;
				pcy0_s2[o] <= cy_s1[o] * HASH_CY;
				pcy1_s2[o] <= cy1_s1[o] * HASH_CY;
				psd_s2[o] <= sd_s1[o] * HASH_SEED;
				tx_s2[o] <= tx_s1[o];
				ty_s2[o] <= ty_s1[o];
				ttx_s2[o] <= sqx[2*WEIGHT_BITS-1:WEIGHT_BITS];
				tty_s2[o] <= sqy[2*WEIGHT_BITS-1:WEIGHT_BITS];
			end
		end

		// corner order: 00, 10, 01, 11 (x then y)
		assign hm[0] = pcx0_s2[o] ^ pcy0_s2[o] ^ psd_s2[o];
		assign hm[1] = pcx1_s2[o] ^ pcy0_s2[o] ^ psd_s2[o];
		assign hm[2] = pcx0_s2[o] ^ pcy1_s2[o] ^ psd_s2[o];
		assign hm[3] = pcx1_s2[o] ^ pcy1_s2[o] ^ psd_s2[o];

		// smoothstep, result stays below 2^16
		assign fpx = (2*WEIGHT_BITS+2)'(ttx_s2[o]) *
			((2*WEIGHT_BITS+2)'(3 << WEIGHT_BITS) - (2*WEIGHT_BITS+2)'({tx_s2[o], 1'b0}));
		assign fpy = (2*WEIGHT_BITS+2)'(tty_s2[o]) *
			((2*WEIGHT_BITS+2)'(3 << WEIGHT_BITS) - (2*WEIGHT_BITS+2)'({ty_s2[o], 1'b0}));

		always_ff @(posedge clk) begin
			if (en[3]) begin
				for (int c = 0; c < 4; c++) begin
					ha_s3[o][c] <= hm[c] ^ (hm[c] >> 13);
				end
				wx_s3[o] <= fpx[2*WEIGHT_BITS-1:WEIGHT_BITS];
				wy_s3[o] <= fpy[2*WEIGHT_BITS-1:WEIGHT_BITS];
			end
		end

		always_ff @(posedge clk) begin
			if (en[4]) begin
				for (int c = 0; c < 4; c++) begin
					hb_s4[o][c] <= ha_s3[o][c] * HASH_M1;
				end
				wx_s4[o] <= wx_s3[o];
				wy_s4[o] <= wy_s3[o];
			end
		end

		always_ff @(posedge clk) begin
			if (en[5]) begin
				for (int c = 0; c < 4; c++) begin
					hc_s5[o][c] <= (hb_s4[o][c] ^ (hb_s4[o][c] >> 15)) * HASH_M2;
				end
				wx_s5[o] <= wx_s4[o];
				wy_s5[o] <= wy_s4[o];
			end
		end

		always_ff @(posedge clk) begin
			if (en[6]) begin
				for (int c = 0; c < 4; c++) begin
					cv_s6[o][c] <= hc_s5[o][c][UNIT_BITS-1:0] ^ hc_s5[o][c][HASH_W-1:16];
				end
				wx_s6[o] <= wx_s5[o];
				wy_s6[o] <= wy_s5[o];
			end
		end

		// bilinear blend along x for both rows
		assign tpp = PW'(cv_s6[o][0]) * (PW'(1 << WEIGHT_BITS) - PW'(wx_s6[o]))
			+ PW'(cv_s6[o][1]) * PW'(wx_s6[o]);
		assign btp = PW'(cv_s6[o][2]) * (PW'(1 << WEIGHT_BITS) - PW'(wx_s6[o]))
			+ PW'(cv_s6[o][3]) * PW'(wx_s6[o]);

		always_ff @(posedge clk) begin
			if (en[7]) begin
				top_s7[o] <= tpp[WEIGHT_BITS +: UNIT_BITS];
				bot_s7[o] <= btp[WEIGHT_BITS +: UNIT_BITS];
				wy_s7[o] <= wy_s6[o];
			end
		end

		assign vvp = PW'(top_s7[o]) * (PW'(1 << WEIGHT_BITS) - PW'(wy_s7[o]))
			+ PW'(bot_s7[o]) * PW'(wy_s7[o]);
		assign vv = vvp[WEIGHT_BITS +: UNIT_BITS];

		always_ff @(posedge clk) begin
			if (en[8]) begin
				n_s8[o] <= (UNIT_BITS+1)'({vv, 1'b0}) - (UNIT_BITS+1)'(1 << UNIT_BITS);
			end
		end

		// amplitude 2^(k-1-o), lanes past the octave count add nothing
		assign sh = k_eff - K_W'(o) - K_W'(1);

		always_ff @(posedge clk) begin
			if (en[9]) begin
				term_s9[o] <= (K_W'(o) < k_eff) ? (SW'(n_s8[o]) <<< sh) : '0;
			end
		end
	end

	// octave sum
	logic signed [SW-1:0] sum_c;
	logic signed [SW-1:0] sum_s10;

	always_comb begin
		sum_c = '0;
		for (int o = 0; o < MAX_OCTAVES; o++) begin
			sum_c = sum_c + term_s9[o];
		end
	end

	always_ff @(posedge clk) begin
		if (en[10]) begin
			sum_s10 <= sum_c;
		end
	end

	// divisor (2^k - 1) << 8, rounding bias half of it
	logic [MAX_OCTAVES-1:0] ones;
	logic [NW-1:0] mag;
	logic [NW-1:0] num_s11;
	logic [DW-1:0] den_s11;
	logic neg_s11;

	always_comb begin
		for (int i = 0; i < MAX_OCTAVES; i++) begin
			ones[i] = K_W'(i) < k_eff;
		end
	end

	assign mag = sum_s10[SW-1] ? NW'(-sum_s10) : NW'(sum_s10);

	always_ff @(posedge clk) begin
		if (en[11]) begin
			num_s11 <= mag + NW'({ones, {(DEN_SHIFT-1){1'b0}}});
			den_s11 <= {ones, {DEN_SHIFT{1'b0}}};
			neg_s11 <= sum_s10[SW-1];
		end
	end

	// restoring divider, one quotient bit per stage from the top
	logic [NW-1:0] rem_sdv [QUOT_BITS-1];
	logic [DW-1:0] den_sdv [QUOT_BITS-1];
	logic [QUOT_BITS-1:0] q_sdv [QUOT_BITS];
	logic neg_sdv [QUOT_BITS];

	for (genvar j = 0; j < QUOT_BITS; j++) begin : g_div
		localparam int B = QUOT_BITS - 1 - j;
		logic [NW-1:0] rin;
		logic [DW-1:0] din;
		logic [QUOT_BITS-1:0] qin;
		logic [QUOT_BITS-1:0] qnew;
		logic nin;
		logic [NW-1:0] dsh;
		logic ge;

		if (j == 0) begin : g_first
			assign rin = num_s11;
			assign din = den_s11;
			assign qin = '0;
			assign nin = neg_s11;
		end else begin : g_next
			assign rin = rem_sdv[j-1];
			assign din = den_sdv[j-1];
			assign qin = q_sdv[j-1];
			assign nin = neg_sdv[j-1];
		end

		assign dsh = NW'(din) << B;
		assign ge = rin >= dsh;

		always_comb begin
			qnew = qin;
			qnew[B] = ge;
		end

		always_ff @(posedge clk) begin
			if (en[DIV_ST0+j]) begin
				q_sdv[j] <= qnew;
				neg_sdv[j] <= nin;
			end
		end

		if (j < QUOT_BITS - 1) begin : g_rem
			always_ff @(posedge clk) begin
				if (en[DIV_ST0+j]) begin
					rem_sdv[j] <= ge ? rin - dsh : rin;
					den_sdv[j] <= din;
				end
			end
		end
	end

	logic signed [OUT_W-1:0] noise_s29;

	always_ff @(posedge clk) begin
		if (en[NST]) begin
			noise_s29 <= neg_sdv[QUOT_BITS-1] ? -OUT_W'(q_sdv[QUOT_BITS-1])
				: OUT_W'(q_sdv[QUOT_BITS-1]);
		end
	end

	assign noise_value = noise_s29;

endmodule

FILE: rtl/core/fbmvn_chk.sv
// port-level checks for the fractal value noise pipeline, bound to the top level
module fbmvn_chk (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               in_stall,
	input logic                               out_valid,
	input logic                               out_stall,
	input logic signed [fbmvn_pkg::OUT_W-1:0] noise_value
);
	import fbmvn_pkg::*;

	localparam logic signed [OUT_W-1:0] ONE_Q16 = OUT_W'(1 << 16);

	// a held result keeps its value
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(noise_value))
		else $error("stalled result changed");

	// normalized noise never leaves [-1, 1]
	a_out_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (noise_value <= ONE_Q16) && (noise_value >= -ONE_Q16))
		else $error("noise value out of range");

	// backpressure only comes from a stalled result at the output
	a_stall_source: assert property (@(posedge clk) disable iff (!arst_n)
		(!out_valid || !out_stall) |-> !in_stall)
		else $error("input stalled while output can move");

endmodule

bind fbm_value_noise fbmvn_chk u_fbmvn_chk (.*);

FILE: bench/tb_top.sv
// testbench for the fractal value noise pipeline: directed table, random points, predictor check
`timescale 1ns / 100ps

module tb_top;
	import fbmvn_pkg::*;

	localparam int LATENCY = 29;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int N_RANDOM = 700;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_idx = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [COORD_W-1:0] coord_x = '0;
	logic signed [COORD_W-1:0] coord_y = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [OUT_W-1:0] noise_value;

	fbm_value_noise uut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
		.cfg_data(cfg_data), .in_valid(in_valid), .in_stall(in_stall),
		.coord_x(coord_x), .coord_y(coord_y), .out_valid(out_valid),
		.out_stall(out_stall), .noise_value(noise_value)
	);

	always #5 clk = ~clk;

	// shadow copy of the configuration registers
	logic [OCT_W-1:0] octaves_reg = 4'd1;
	logic [SEED_W-1:0] seed_reg = '0;

	logic signed [OUT_W-1:0] pending_noise[$];
	int mismatches = 0;
	int idle_cycles = 0;
	bit no_idle = 1'b0;
	bit hold_off = 1'b0;

	function automatic logic [31:0] corner_hash(logic [31:0] cx, logic [31:0] cy,
			logic [31:0] s);
		logic [31:0] h;
		h = cx * HASH_CX;
		h ^= cy * HASH_CY;
		h ^= s * HASH_SEED;
		h ^= h >> 13;
		h *= HASH_M1;
		h ^= h >> 15;
		h *= HASH_M2;
		h ^= h >> 16;
		return h & 32'h00ffffff;
	endfunction

	function automatic logic [63:0] smooth_weight(logic [63:0] t);
		logic [63:0] t2;
		t2 = (t * t) >> 16;
		return (t2 * ((64'd3 << 16) - 2 * t)) >> 16;
	endfunction

	function automatic logic [63:0] lerp_unit(logic [63:0] a, logic [63:0] b,
			logic [63:0] w);
		return (a * ((64'd1 << 16) - w) + b * w) >> 16;
	endfunction

	function automatic logic signed [63:0] octave_value(logic [63:0] sx, logic [63:0] sy,
			logic [31:0] s);
		logic [31:0] cx, cy;
		logic [63:0] wx, wy, top, bot, v;
		cx = sx[47:16];
		cy = sy[47:16];
		wx = smooth_weight({48'd0, sx[15:0]});
		wy = smooth_weight({48'd0, sy[15:0]});
		top = lerp_unit(corner_hash(cx, cy, s), corner_hash(cx + 1, cy, s), wx);
		bot = lerp_unit(corner_hash(cx, cy + 1, s), corner_hash(cx + 1, cy + 1, s), wx);
		v = lerp_unit(top, bot, wy);
		return $signed(2 * v) - $signed(64'd1 << 24);
	endfunction

	function automatic logic signed [OUT_W-1:0] fbm_noise(logic signed [31:0] x,
			logic signed [31:0] y);
		int k;
		logic [63:0] bx, by, mag, den, q;
		logic signed [63:0] sum;
		k = octaves_reg;
		if (k < 1) k = 1;
		if (k > DEF_MAX_OCTAVES) k = DEF_MAX_OCTAVES;
		bx = 64'(x);
		by = 64'(y);
		sum = 0;
		for (int o = 0; o < k; o++)
			sum += octave_value(bx << o, by << o, seed_reg + o * SEED_STEP)
				* $signed(64'd1 << (k - 1 - o));
		den = ((64'd1 << k) - 1) << 8;
		mag = sum < 0 ? -sum : sum;
		q = (mag + den / 2) / den;
		return sum < 0 ? OUT_W'(-q) : OUT_W'(q);
	endfunction

	task automatic write_reg(cfg_reg_t idx, logic [31:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_OCTAVE_COUNT) octaves_reg = val[3:0];
		else seed_reg = val;
	endtask

	// a block that holds no work: all expected results back plus latency
	task automatic drain();
		in_valid <= 1'b0;
		while (pending_noise.size() != 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	// drive one request; expected is queued when accepted, valid stays up for the next one
	task automatic send_point(logic signed [31:0] x, logic signed [31:0] y,
			bit use_fixed, logic signed [OUT_W-1:0] fixed_val);
		logic signed [OUT_W-1:0] want;
		if (!no_idle && $urandom_range(0, 7) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		in_valid <= 1'b1;
		coord_x <= x;
		coord_y <= y;
		do @(posedge clk); while (in_stall);
		want = use_fixed ? fixed_val : fbm_noise(x, y);
		pending_noise = {pending_noise, want};
	endtask

	typedef struct {
		logic signed [31:0] x;
		logic signed [31:0] y;
		bit fixed;
		logic signed [OUT_W-1:0] want;
	} point_row_t;

	point_row_t directed[] = '{
		'{32'sh0, 32'sh0, 1'b0, '0},
		'{32'sh7fffffff, 32'sh7fffffff, 1'b0, '0},
		'{32'sh80000000, 32'sh80000000, 1'b0, '0},
		'{32'sh80000000, 32'sh7fffffff, 1'b0, '0},
		'{32'sh0000ffff, 32'sh00008000, 1'b0, '0},
		'{32'shffff0000, 32'sh00010000, 1'b0, '0},
		'{32'shffffffff, 32'sh0, 1'b0, '0},
		'{32'sh55555555, 32'shaaaaaaaa, 1'b0, '0},
		'{32'shaaaaaaaa, 32'sh55555555, 1'b0, '0},
		'{32'sh12345678, 32'shfedcba98, 1'b0, '0}
	};

	// output side: random stall bursts, checks against oldest expectation
	always @(posedge clk) begin
		if (out_valid && !out_stall) begin
			if (pending_noise.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected noise_value %0d", noise_value);
			end else begin
				logic signed [OUT_W-1:0] want;
				want = pending_noise.pop_front();
				if (want !== noise_value) begin
					mismatches++;
					if (mismatches <= 10)
						$display("noise_value mismatch: expected %0d got %0d", want,
							noise_value);
				end
			end
		end
	end

	int stall_left = 0;
	always @(posedge clk) begin
		if (hold_off) begin
			out_stall <= 1'b1;
		end else if (no_idle) begin
			out_stall <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_stall <= 1'b1;
		end else if ($urandom_range(0, 5) == 0) begin
			stall_left <= $urandom_range(0, 4);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// watchdog on cycles with no accepted request either side and no configuration write
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("[fbm_value_noise] ERROR");
			$finish;
		end
	end

	logic [3:0] oct_settings[] = '{4'd0, 4'd1, 4'd8, 4'd15, 4'd3, 4'd9, 4'd5};
	logic [31:0] seed_settings[] = '{32'd0, 32'hffffffff, 32'h9e3779b9, 32'd1,
		32'h80000000, 32'h0000ffff, 32'h5a5a5a5a};

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		// reset config: one octave, seed zero
		foreach (directed[i])
			send_point(directed[i].x, directed[i].y, directed[i].fixed, directed[i].want);
		drain();
		// long receiver hold-off while the sender keeps pushing
		hold_off = 1'b1;
		fork
			begin
				repeat (200) @(posedge clk);
				hold_off = 1'b0;
			end
			for (int i = 0; i < 60; i++) send_point($urandom, $urandom, 1'b0, '0);
		join
		drain();
		foreach (oct_settings[p]) begin
			write_reg(REG_OCTAVE_COUNT, {28'd0, oct_settings[p]});
			write_reg(REG_NOISE_SEED, seed_settings[p]);
			if (p == oct_settings.size() - 1) no_idle = 1'b1;
			for (int i = 0; i < N_RANDOM / 7; i++) begin
				logic signed [31:0] x, y;
				case ($urandom_range(0, 3))
					0: begin x = $urandom; y = $urandom; end
					1: begin
						x = $signed($urandom_range(0, 32'h000fffff)) - 32'sh00080000;
						y = $signed($urandom_range(0, 32'h000fffff)) - 32'sh00080000;
					end
					2: begin
						x = {$urandom_range(0, 1) ? 16'hffff : 16'h0000, 16'($urandom)};
						y = {$urandom_range(0, 1) ? 16'h7fff : 16'h8000, 16'($urandom)};
					end
					default: begin x = $urandom; y = {16'($urandom), 16'h0}; end
				endcase
				send_point(x, y, 1'b0, '0);
			end
			drain();
		end
		if (mismatches == 0 && pending_noise.size() == 0)
			$display("[fbm_value_noise] OK");
		else
			$display("[fbm_value_noise] ERROR");
		$finish;
	end

endmodule
